// File: sv/multilevel_priority_scheduler_assert.svh
// Assertion macros for the multilevel priority scheduler.
`ifndef MULTILEVEL_PRIORITY_SCHEDULER_ASSERT_SVH
`define MULTILEVEL_PRIORITY_SCHEDULER_ASSERT_SVH
`ifndef SYNTH
`define MSCHED_ASSERT_IMP(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("scheduler assertion failed");
`define MSCHED_ASSERT_NXT(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("scheduler assertion failed");
`else
`define MSCHED_ASSERT_IMP(lbl, ante, cons)
`define MSCHED_ASSERT_NXT(lbl, ante, cons)
`endif
`endif

// File: sv/msched_pkg.sv
// Shared types and constants of the multilevel priority scheduler.
`default_nettype none
package msched_pkg;

    localparam int DEF_MAX_JOBS    = 16;
    localparam int DEF_PRIO_LEVELS = 8;
    localparam int TICK_W          = 23;
    localparam int IN_DATA_W       = 56;
    localparam int OUT_DATA_W      = 88;

    typedef enum logic [2:0] {
        S_LOAD,
        S_START,
        S_SCAN,
        S_DECIDE,
        S_OVF,
        S_CLEAR
    } state_t;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic load;
        logic scan_init;
        logic scan_step;
        logic serve;
        logic jump;
        logic emit_ovf;
        logic clear;
    } cmd_t;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic scan_last;
        logic found;
        logic overflow;
        logic out_free;
        logic final_serve;
    } stat_t;

endpackage
`default_nettype wire

// File: sv/msched_ctrl.sv
// Controller state machine of the multilevel priority scheduler.
`default_nettype none
module msched_ctrl (
    input  wire logic            clk,
    input  wire logic            rst_n,
    input  wire logic            s_tvalid,
    input  wire logic            s_tlast,
    output logic                 s_tready,
    input  msched_pkg::stat_t    stat,
    output msched_pkg::cmd_t     cmd
);
    import msched_pkg::*;

    state_t state_reg;
    state_t state_next;

    // State register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_LOAD;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // Next state and commands.
    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        s_tready   = 1'b0;
        case (state_reg)
            S_LOAD:
            begin
                s_tready = 1'b1;
                if (s_tvalid)
                begin
                    cmd.load = 1'b1;
                    if (s_tlast)
                    begin
                        state_next = S_START;
                    end
                end
            end
            S_START:
            begin
                if (stat.overflow)
                begin
                    state_next = S_OVF;
                end
                else
                begin
                    cmd.scan_init = 1'b1;
                    state_next    = S_SCAN;
                end
            end
            S_SCAN:
            begin
                cmd.scan_step = 1'b1;
                if (stat.scan_last)
                begin
                    state_next = S_DECIDE;
                end
            end
            S_DECIDE:
            begin
                if (stat.found)
                begin
                    if (stat.out_free)
                    begin
                        cmd.serve     = 1'b1;
                        cmd.scan_init = 1'b1;
                        state_next    = stat.final_serve ? S_CLEAR : S_SCAN;
                    end
                end
                else
                begin
                    cmd.jump      = 1'b1;
                    cmd.scan_init = 1'b1;
                    state_next    = S_SCAN;
                end
            end
            S_OVF:
            begin
                if (stat.out_free)
                begin
                    cmd.emit_ovf = 1'b1;
                    state_next   = S_CLEAR;
                end
            end
            S_CLEAR:
            begin
                cmd.clear  = 1'b1;
                state_next = S_LOAD;
            end
            default:
            begin
                state_next = S_LOAD;
            end
        endcase
    end

endmodule
`default_nettype wire

// File: sv/msched_dp.sv
// Datapath of the multilevel priority scheduler: job table, scan and result register.
`default_nettype none
module msched_dp #(
    parameter int MAX_JOBS    = msched_pkg::DEF_MAX_JOBS,
    parameter int PRIO_LEVELS = msched_pkg::DEF_PRIO_LEVELS
) (
    input  wire logic                               clk,
    input  wire logic                               rst_n,
    input  wire logic [msched_pkg::IN_DATA_W-1:0]   s_tdata,
    input  msched_pkg::cmd_t                        cmd,
    output msched_pkg::stat_t                       stat,
    output logic                                    m_tvalid,
    input  wire logic                               m_tready,
    output logic [msched_pkg::OUT_DATA_W-1:0]       m_tdata,
    output logic                                    m_tuser,
    output logic                                    m_tlast
);
    import msched_pkg::*;

    localparam int IW = (MAX_JOBS > 1) ? $clog2(MAX_JOBS) : 1;
    localparam int NW = $clog2(MAX_JOBS + 1);
    localparam int LW = $clog2(PRIO_LEVELS);
    localparam int SW = $clog2(2 * MAX_JOBS + 1);
    localparam logic [LW-1:0] LVL_MAX = LW'(PRIO_LEVELS - 1);

    // Job table, written at the load count and read at the scan index.
    logic [15:0]   tab_id  [MAX_JOBS];
    logic [15:0]   tab_arr [MAX_JOBS];
    logic [15:0]   tab_len [MAX_JOBS];
    logic [LW-1:0] tab_lvl [MAX_JOBS];
    logic [SW-1:0] stamp   [MAX_JOBS];

    logic [NW-1:0]       loaded_reg;
    logic                ovf_reg;
    logic [MAX_JOBS-1:0] enq_reg;
    logic [MAX_JOBS-1:0] done_reg;
    logic [NW-1:0]       done_cnt_reg;
    logic [SW-1:0]       dec_reg;
    logic [TICK_W-1:0]   clock_reg;
    logic [IW-1:0]       idx_reg;
    logic                found_reg;
    logic [IW-1:0]       best_idx_reg;
    logic [LW+SW-1:0]    best_key_reg;
    logic [15:0]         best_id_reg;
    logic [15:0]         best_arr_reg;
    logic [15:0]         best_len_reg;
    logic                have_reg;
    logic [15:0]         min_arr_reg;

    logic                out_valid_reg;
    logic [OUT_DATA_W-1:0] out_data_reg;
    logic                out_user_reg;
    logic                out_last_reg;

    // Input fields and level clamp.
    logic [15:0]   in_id;
    logic [15:0]   in_arr;
    logic [15:0]   in_len;
    logic [4:0]    in_prio;
    logic [LW-1:0] in_lvl;
    logic          table_full;

    assign in_id      = s_tdata[15:0];
    assign in_arr     = s_tdata[31:16];
    assign in_len     = s_tdata[47:32];
    assign in_prio    = {2'b00, s_tdata[50:48]};
    assign in_lvl     = (in_prio >= 5'(PRIO_LEVELS)) ? LVL_MAX : LW'(in_prio);
    assign table_full = (loaded_reg == NW'(MAX_JOBS));

    // Evaluation of the job under the scan index.
    logic              cur_enq;
    logic              newly;
    logic              enq_now;
    logic [SW-1:0]     cur_stamp;
    logic [LW+SW-1:0]  cur_key;
    logic              better;
    logic              pbetter;
    logic [15:0]       cur_arr;

    assign cur_arr   = tab_arr[idx_reg];
    assign cur_enq   = enq_reg[idx_reg];
    assign newly     = !cur_enq && (TICK_W'(cur_arr) <= clock_reg);
    assign enq_now   = cur_enq || newly;
    assign cur_stamp = newly ? dec_reg : stamp[idx_reg];
    assign cur_key   = {tab_lvl[idx_reg], cur_stamp};
    assign better    = enq_now && !done_reg[idx_reg] && (!found_reg || cur_key < best_key_reg);
    assign pbetter   = !enq_now && (!have_reg || cur_arr < min_arr_reg);

    // Result arithmetic of the chosen job.
    logic [TICK_W-1:0] fin;
    logic [TICK_W-1:0] wait_t;
    logic [TICK_W-1:0] turn_t;

    assign fin    = clock_reg + TICK_W'(best_len_reg);
    assign wait_t = clock_reg - TICK_W'(best_arr_reg);
    assign turn_t = fin - TICK_W'(best_arr_reg);

    // Table and stamp writes.
    always_ff @(posedge clk)
    begin
        if (cmd.load && !table_full)
        begin
            tab_id[loaded_reg[IW-1:0]]  <= in_id;
            tab_arr[loaded_reg[IW-1:0]] <= in_arr;
            tab_len[loaded_reg[IW-1:0]] <= in_len;
            tab_lvl[loaded_reg[IW-1:0]] <= in_lvl;
        end
        if (cmd.scan_step && newly)
        begin
            stamp[idx_reg] <= dec_reg;
        end
    end

    // Scan best-candidate payload.
    always_ff @(posedge clk)
    begin
        if (cmd.scan_step && better)
        begin
            best_idx_reg <= idx_reg;
            best_key_reg <= cur_key;
            best_id_reg  <= tab_id[idx_reg];
            best_arr_reg <= cur_arr;
            best_len_reg <= tab_len[idx_reg];
        end
        if (cmd.scan_step && pbetter)
        begin
            min_arr_reg <= cur_arr;
        end
    end

    // Set state and scan control.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            loaded_reg   <= '0;
            ovf_reg      <= 1'b0;
            enq_reg      <= '0;
            done_reg     <= '0;
            done_cnt_reg <= '0;
            dec_reg      <= '0;
            clock_reg    <= '0;
            idx_reg      <= '0;
            found_reg    <= 1'b0;
            have_reg     <= 1'b0;
        end
        else if (cmd.clear)
        begin
            loaded_reg   <= '0;
            ovf_reg      <= 1'b0;
            enq_reg      <= '0;
            done_reg     <= '0;
            done_cnt_reg <= '0;
            dec_reg      <= '0;
            clock_reg    <= '0;
            idx_reg      <= '0;
            found_reg    <= 1'b0;
            have_reg     <= 1'b0;
        end
        else
        begin
            if (cmd.load)
            begin
                if (table_full)
                begin
                    ovf_reg <= 1'b1;
                end
                else
                begin
                    loaded_reg <= loaded_reg + NW'(1);
                end
            end
            if (cmd.scan_step)
            begin
                idx_reg <= idx_reg + IW'(1);
                if (newly)
                begin
                    enq_reg[idx_reg] <= 1'b1;
                end
                if (better)
                begin
                    found_reg <= 1'b1;
                end
                if (pbetter)
                begin
                    have_reg <= 1'b1;
                end
            end
            if (cmd.serve)
            begin
                clock_reg              <= fin;
                done_reg[best_idx_reg] <= 1'b1;
                done_cnt_reg           <= done_cnt_reg + NW'(1);
                dec_reg                <= dec_reg + SW'(1);
            end
            if (cmd.jump)
            begin
                clock_reg <= TICK_W'(min_arr_reg);
                dec_reg   <= dec_reg + SW'(1);
            end
            if (cmd.scan_init)
            begin
                idx_reg   <= '0;
                found_reg <= 1'b0;
                have_reg  <= 1'b0;
            end
        end
    end

    // Output beat register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (cmd.serve || cmd.emit_ovf)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (m_tready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.serve)
        begin
            out_data_reg <= {3'b000, turn_t, wait_t, fin, best_id_reg};
            out_user_reg <= 1'b0;
            out_last_reg <= (done_cnt_reg + NW'(1) == loaded_reg);
        end
        else if (cmd.emit_ovf)
        begin
            out_data_reg <= '0;
            out_user_reg <= 1'b1;
            out_last_reg <= 1'b1;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;
    assign m_tuser  = out_user_reg;
    assign m_tlast  = out_last_reg;

    // Status to the controller.
    assign stat.scan_last   = (NW'(idx_reg) + NW'(1) == loaded_reg);
    assign stat.found       = found_reg;
    assign stat.overflow    = ovf_reg;
    assign stat.out_free    = !out_valid_reg || m_tready;
    assign stat.final_serve = (done_cnt_reg + NW'(1) == loaded_reg);

endmodule
`default_nettype wire

// File: sv/multilevel_priority_scheduler.sv
// Top level of the multilevel priority scheduler.
// Jobs are loaded one beat per cycle; the beat with tlast starts the schedule. Each
// scheduling decision is one pass of the job-table scan over the n loaded jobs, and a
// set needs at most 2n decisions (one service per job plus idle time jumps). A serving
// decision stalls while a finished result still waits for the receiver.
// Results leave in service order, one beat per job, with tlast on the final one; an
// overloaded table gives a single beat with tuser set. No new job is accepted until the
// final result of the set has been placed in the output register.
`default_nettype none
`include "multilevel_priority_scheduler_assert.svh"
module multilevel_priority_scheduler #(
    parameter int MAX_JOBS    = msched_pkg::DEF_MAX_JOBS,
    parameter int PRIO_LEVELS = msched_pkg::DEF_PRIO_LEVELS
) (
    input  wire logic                             clk,
    input  wire logic                             rst_n,
    input  wire logic                             s_tvalid,
    output logic                                  s_tready,
    // job_id[15:0], arrival_tick[31:16], run_length[47:32], prio_level[50:48]
    input  wire logic [msched_pkg::IN_DATA_W-1:0] s_tdata,
    input  wire logic                             s_tlast,
    output logic                                  m_tvalid,
    input  wire logic                             m_tready,
    // served_id[15:0], finish_tick[38:16], wait_ticks[61:39], turnaround_ticks[84:62]
    output logic [msched_pkg::OUT_DATA_W-1:0]     m_tdata,
    // overflow[0]
    output logic                                  m_tuser,
    output logic                                  m_tlast
);
    import msched_pkg::*;

    cmd_t  cmd;
    stat_t stat;

    // Controller.
    msched_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tlast  (s_tlast),
        .s_tready (s_tready),
        .stat     (stat),
        .cmd      (cmd)
    );

    // Datapath.
    msched_dp #(
        .MAX_JOBS    (MAX_JOBS),
        .PRIO_LEVELS (PRIO_LEVELS)
    ) u_dp (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tdata  (s_tdata),
        .cmd      (cmd),
        .stat     (stat),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .m_tlast  (m_tlast)
    );

    // Checks on the controller and datapath interplay.
    `MSCHED_ASSERT_IMP(a_one_cmd, 1'b1, $onehot0({cmd.load, cmd.serve, cmd.jump, cmd.emit_ovf, cmd.clear}))
    `MSCHED_ASSERT_IMP(a_serve_room, cmd.serve || cmd.emit_ovf, stat.out_free)
    `MSCHED_ASSERT_NXT(a_out_hold, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata))

endmodule
`default_nettype wire
